### rtl/bse_pkg.sv
// Shared constants and widths for the battery state-of-charge estimator.
// No dependencies; every other file of the block but bse_ram uses this package.
`default_nettype none

package bse_pkg;

    // Sizing of the averaging ring and the charge table
    localparam int WINDOW_MAX = 64;
    localparam int TABLE_MAX  = 16;

    // Field widths
    localparam int ADC_W     = 10;
    localparam int VOLT_W    = 16;
    localparam int CHG_W     = 7;
    localparam int IDX_W     = 4;
    localparam int WIN_CFG_W = 7;
    localparam int TBL_CFG_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_USED = 1'd1;
    localparam int WIN_RESET = 8;
    localparam int TBL_RESET = 16;

    // Scaling: volts = avg * 5 * 9 / 1023, reported in Q6.10
    localparam int ADC_FULL = 1023;
    localparam int VOLT_NUM = 5 * 9 * 1024;

    // Derived widths
    localparam int SLOT_W  = $clog2(WINDOW_MAX);
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = $clog2(WINDOW_MAX * ADC_FULL + 1);
    localparam int TADDR_W = $clog2(TABLE_MAX);
    localparam int TCNT_W  = $clog2(TABLE_MAX + 1);
    localparam int PROD_W  = CHG_W + VOLT_W;
    localparam int DIVD_W  = SUM_W + VOLT_W;
    localparam int DVSR_W  = (FILL_W + ADC_W > VOLT_W) ? FILL_W + ADC_W : VOLT_W;
    localparam int STEP_W  = $clog2(DIVD_W + 1);

endpackage

`default_nettype wire

### rtl/bse_if.sv
// Channel interfaces of the estimator: request, result and configuration.
// Depends on bse_pkg for field widths.
`default_nettype none

interface bse_req_if;
    import bse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ADC_W-1:0]     adc_sample;
    logic [IDX_W-1:0]     entry_index;
    logic [VOLT_W-1:0]    entry_voltage;
    logic [CHG_W-1:0]     entry_charge;

    modport source (output valid, req_type, adc_sample, entry_index, entry_voltage,
                    entry_charge, input ready);
    modport sink   (input valid, req_type, adc_sample, entry_index, entry_voltage,
                    entry_charge, output ready);
endinterface

interface bse_res_if;
    import bse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VOLT_W-1:0]    avg_voltage;
    logic [CHG_W-1:0]     charge_pct;

    modport source (output valid, avg_voltage, charge_pct, input ready);
    modport sink   (input valid, avg_voltage, charge_pct, output ready);
endinterface

interface bse_cfg_if;
    import bse_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

`default_nettype wire

### rtl/bse_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on bse_pkg for operand widths.
`default_nettype none

module bse_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bse_pkg::DIVD_W-1:0]  dividend,
    input  logic [bse_pkg::DVSR_W-1:0]  divisor,
    output logic                        busy,
    output logic [bse_pkg::DIVD_W-1:0]  quotient
);
    import bse_pkg::*;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W:0]   shifted;
    logic [DVSR_W:0]   diff;
    logic              fits;

    // shift in the next dividend bit and try a subtract
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = !diff[DVSR_W];

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            cnt_next  = STEP_W'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            rem_next = fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
endmodule

`default_nettype wire

### rtl/battery_soc_estimator.sv
// Battery state-of-charge estimator: moving average plus table interpolation.
// A sample request updates the ring, divides for the voltage, checks it against the first
// and last breakpoints (clamping to either), else scans the table and divides again to
// interpolate; the next request is taken once the result is loaded and the sequencer has
// returned to idle. A table write needs no divider. Most of the time goes to the serial
// divider and the table scan step. Reset clears averaging, window_len = 8, table_used = 16.
`default_nettype none

module battery_soc_estimator (
    input  logic       clk,
    input  logic       rst_n,
    bse_req_if.sink    req,
    bse_res_if.source  res,
    bse_cfg_if.sink    cfg
);
    import bse_pkg::*;

    // Microcode definitions
    typedef enum logic [3:0] {
        OP_NOP,
        OP_RING_RD,
        OP_RING_UPD,
        OP_VDIV_START,
        OP_VOLT_SAVE,
        OP_CHK_FIRST,
        OP_CHK_LAST,
        OP_SCAN,
        OP_IMUL,
        OP_IDIV_START,
        OP_CHG_SAVE,
        OP_EMIT,
        OP_TBL_WR
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_IS_WRITE,
        C_DIV_BUSY,
        C_LE_ENTRY,
        C_GE_ENTRY,
        C_LT_ENTRY,
        C_OUT_FULL
    } cond_t;

    localparam int PC_W = 5;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [CHG_W-1:0]  chg;
    } bkpt_t;

    localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] PC_VDIV_WAIT = 5'd5;
    localparam logic [PC_W-1:0] PC_SCAN      = 5'd9;
    localparam logic [PC_W-1:0] PC_IMUL      = 5'd11;
    localparam logic [PC_W-1:0] PC_IDIV_WAIT = 5'd13;
    localparam logic [PC_W-1:0] PC_EMIT      = 5'd15;
    localparam logic [PC_W-1:0] PC_TBL_WR    = 5'd17;

    // Control store
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        begin
            case (addr)
                5'd0:    w = '{op: OP_NOP,        cond: C_NO_REQ,   target: PC_IDLE};
                5'd1:    w = '{op: OP_NOP,        cond: C_IS_WRITE, target: PC_TBL_WR};
                5'd2:    w = '{op: OP_RING_RD,    cond: C_NEVER,    target: PC_IDLE};
                5'd3:    w = '{op: OP_RING_UPD,   cond: C_NEVER,    target: PC_IDLE};
                5'd4:    w = '{op: OP_VDIV_START, cond: C_NEVER,    target: PC_IDLE};
                5'd5:    w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: PC_VDIV_WAIT};
                5'd6:    w = '{op: OP_VOLT_SAVE,  cond: C_NEVER,    target: PC_IDLE};
                5'd7:    w = '{op: OP_CHK_FIRST,  cond: C_LE_ENTRY, target: PC_EMIT};
                5'd8:    w = '{op: OP_CHK_LAST,   cond: C_GE_ENTRY, target: PC_EMIT};
                5'd9:    w = '{op: OP_SCAN,       cond: C_LT_ENTRY, target: PC_IMUL};
                5'd10:   w = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_SCAN};
                5'd11:   w = '{op: OP_IMUL,       cond: C_NEVER,    target: PC_IDLE};
                5'd12:   w = '{op: OP_IDIV_START, cond: C_NEVER,    target: PC_IDLE};
                5'd13:   w = '{op: OP_NOP,        cond: C_DIV_BUSY, target: PC_IDIV_WAIT};
                5'd14:   w = '{op: OP_CHG_SAVE,   cond: C_NEVER,    target: PC_IDLE};
                5'd15:   w = '{op: OP_EMIT,       cond: C_OUT_FULL, target: PC_EMIT};
                5'd16:   w = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
                5'd17:   w = '{op: OP_TBL_WR,     cond: C_ALWAYS,   target: PC_IDLE};
                default: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: PC_IDLE};
            endcase
            return w;
        end
    endfunction

    localparam logic [VOLT_W-1:0] VOLT_NUM_V = VOLT_W'(VOLT_NUM);
    localparam logic [ADC_W-1:0]  ADC_FULL_V = ADC_W'(ADC_FULL);

    // Sequencer
    uword_t          cw;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    // Configuration
    logic                 cfg_fire;
    logic                 win_wr;
    logic [WIN_CFG_W-1:0] win_len_reg, win_len_next;
    logic [TBL_CFG_W-1:0] tbl_used_reg, tbl_used_next;
    logic [FILL_W-1:0]    eff_win;
    logic [TCNT_W-1:0]    eff_tbl;
    logic [TADDR_W-1:0]   last_addr;

    // Latched request
    logic                 req_fire;
    logic                 typ_reg;
    logic [ADC_W-1:0]     smp_reg;
    logic [IDX_W-1:0]     eidx_reg;
    logic [VOLT_W-1:0]    evolt_reg;
    logic [CHG_W-1:0]     echg_reg;

    // Averaging state
    logic [WINDOW_MAX-1:0] valid_reg, valid_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [SLOT_W-1:0]     slot_use;
    logic [FILL_W-1:0]     slot_inc;
    logic [SLOT_W-1:0]     slot_adv;
    logic [ADC_W-1:0]      ring_rdata;
    logic [ADC_W-1:0]      old_smp;
    logic [SUM_W-1:0]      sum_upd;

    // Table lookup
    logic                  tbl_wr_en;
    logic                  tbl_rd_en;
    logic [TADDR_W-1:0]    tbl_rd_addr;
    bkpt_t                 tbl_rdata;
    bkpt_t                 tbl_wdata;
    bkpt_t                 lo_reg;
    logic [TADDR_W-1:0]    idx_reg;
    logic [VOLT_W-1:0]     volts_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     lo_term;
    logic [PROD_W-1:0]     hi_term;
    logic [VOLT_W-1:0]     span;
    logic [CHG_W-1:0]      charge_reg;
    logic                  above_entry;

    // Divider
    logic                  div_start;
    logic                  div_busy;
    logic [DIVD_W-1:0]     div_dividend;
    logic [DVSR_W-1:0]     div_divisor;
    logic [DIVD_W-1:0]     div_quo;
    logic [DIVD_W-1:0]     vprod;
    logic [DVSR_W-1:0]     vden;

    // Result register
    logic                  out_full;
    logic                  out_valid_reg, out_valid_next;
    logic [VOLT_W-1:0]     out_volt_reg;
    logic [CHG_W-1:0]      out_chg_reg;

    // Handshakes
    assign req.ready = (pc_reg == PC_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign out_full  = out_valid_reg && !res.ready;

    // Sequencer: jump when the selected condition holds
    assign cw          = ucode_rom(pc_reg);
    assign above_entry = !(volts_reg < tbl_rdata.volt);

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !req_fire;
            C_IS_WRITE: take = typ_reg;
            C_DIV_BUSY: take = div_busy;
            C_LE_ENTRY: take = (volts_reg <= tbl_rdata.volt);
            C_GE_ENTRY: take = above_entry;
            C_LT_ENTRY: take = !above_entry;
            C_OUT_FULL: take = out_full;
            default:    take = 1'b0;
        endcase
        pc_next = take ? cw.target : pc_reg + PC_W'(1);
    end

    // Effective window and table sizes
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            eff_win = FILL_W'(1);
        end
        else if (int'(win_len_reg) > WINDOW_MAX)
        begin
            eff_win = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            eff_win = FILL_W'(win_len_reg);
        end

        if (int'(tbl_used_reg) < 2)
        begin
            eff_tbl = TCNT_W'(2);
        end
        else if (int'(tbl_used_reg) > TABLE_MAX)
        begin
            eff_tbl = TCNT_W'(TABLE_MAX);
        end
        else
        begin
            eff_tbl = TCNT_W'(tbl_used_reg);
        end
    end

    assign last_addr = TADDR_W'(eff_tbl - TCNT_W'(1));

    // Configuration writes
    always_comb
    begin
        win_len_next  = win_len_reg;
        tbl_used_next = tbl_used_reg;
        win_wr        = 1'b0;
        if (cfg_fire)
        begin
            case (cfg.index)
                REG_WINDOW_LEN:
                begin
                    win_len_next = cfg.data[WIN_CFG_W-1:0];
                    win_wr       = 1'b1;
                end
                REG_TABLE_USED:
                begin
                    tbl_used_next = cfg.data[TBL_CFG_W-1:0];
                end
                default:
                begin
                    win_wr = 1'b0;
                end
            endcase
        end
    end

    // Ring slot arithmetic
    assign slot_use = (FILL_W'(slot_reg) >= eff_win) ? '0 : slot_reg;
    assign slot_inc = FILL_W'(slot_reg) + FILL_W'(1);
    assign slot_adv = (slot_inc >= eff_win) ? '0 : SLOT_W'(slot_inc);
    assign old_smp  = valid_reg[slot_reg] ? ring_rdata : '0;
    assign sum_upd  = sum_reg - SUM_W'(old_smp) + SUM_W'(smp_reg);

    // Averaging state update; a window_len write restarts the average
    always_comb
    begin
        valid_next = valid_reg;
        sum_next   = sum_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        if (win_wr)
        begin
            valid_next = '0;
            sum_next   = '0;
            slot_next  = '0;
            fill_next  = '0;
        end
        else
        begin
            case (cw.op)
                OP_RING_RD:
                begin
                    slot_next = slot_use;
                end
                OP_RING_UPD:
                begin
                    sum_next             = sum_upd;
                    slot_next            = slot_adv;
                    valid_next[slot_reg] = 1'b1;
                    if (fill_reg < eff_win)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    // Result register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cw.op == OP_EMIT && !out_full)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            win_len_reg   <= WIN_CFG_W'(WIN_RESET);
            tbl_used_reg  <= TBL_CFG_W'(TBL_RESET);
            valid_reg     <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            win_len_reg   <= win_len_next;
            tbl_used_reg  <= tbl_used_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sample ring storage
    bse_ram #(
        .WIDTH (ADC_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (cw.op == OP_RING_UPD),
        .wr_addr (slot_reg),
        .wr_data (smp_reg),
        .rd_en   (cw.op == OP_RING_RD),
        .rd_addr (slot_use),
        .rd_data (ring_rdata)
    );

    // Breakpoint table storage
    assign tbl_wr_en = (cw.op == OP_TBL_WR) && (int'(eidx_reg) < TABLE_MAX);
    assign tbl_wdata = '{volt: evolt_reg, chg: echg_reg};

    always_comb
    begin
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = '0;
        case (cw.op)
            OP_VOLT_SAVE:
            begin
                tbl_rd_en = 1'b1;
            end
            OP_CHK_FIRST:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = last_addr;
            end
            OP_CHK_LAST:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = TADDR_W'(1);
            end
            OP_SCAN:
            begin
                tbl_rd_en   = above_entry;
                tbl_rd_addr = idx_reg + TADDR_W'(1);
            end
            default:
            begin
                tbl_rd_en = 1'b0;
            end
        endcase
    end

    bse_ram #(
        .WIDTH (VOLT_W + CHG_W),
        .DEPTH (TABLE_MAX)
    ) u_tbl_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (TADDR_W'(eidx_reg)),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rdata)
    );

    // Divider operands: voltage scaling or interpolation
    assign vprod   = DIVD_W'(sum_reg) * DIVD_W'(VOLT_NUM_V);
    assign vden    = DVSR_W'(fill_reg) * DVSR_W'(ADC_FULL_V);
    assign lo_term = PROD_W'(lo_reg.chg) * PROD_W'(tbl_rdata.volt - volts_reg);
    assign hi_term = PROD_W'(tbl_rdata.chg) * PROD_W'(volts_reg - lo_reg.volt);
    assign span    = tbl_rdata.volt - lo_reg.volt;

    assign div_start    = (cw.op == OP_VDIV_START) || (cw.op == OP_IDIV_START);
    assign div_dividend = (cw.op == OP_IDIV_START) ?
                          (DIVD_W'(prod_reg) + DIVD_W'(hi_term)) : vprod;
    assign div_divisor  = (cw.op == OP_IDIV_START) ? DVSR_W'(span) : vden;

    bse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Request latch
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            typ_reg   <= req.req_type;
            smp_reg   <= req.adc_sample;
            eidx_reg  <= req.entry_index;
            evolt_reg <= req.entry_voltage;
            echg_reg  <= req.entry_charge;
        end
    end

    // Lookup datapath registers
    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_VOLT_SAVE:
            begin
                volts_reg <= (|div_quo[DIVD_W-1:VOLT_W]) ? '1 : div_quo[VOLT_W-1:0];
            end
            OP_CHK_FIRST:
            begin
                lo_reg     <= tbl_rdata;
                charge_reg <= tbl_rdata.chg;
            end
            OP_CHK_LAST:
            begin
                charge_reg <= tbl_rdata.chg;
                idx_reg    <= TADDR_W'(1);
            end
            OP_SCAN:
            begin
                if (above_entry)
                begin
                    lo_reg  <= tbl_rdata;
                    idx_reg <= idx_reg + TADDR_W'(1);
                end
            end
            OP_IMUL:
            begin
                prod_reg <= lo_term;
            end
            OP_CHG_SAVE:
            begin
                charge_reg <= div_quo[CHG_W-1:0];
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cw.op == OP_EMIT && !out_full)
        begin
            out_volt_reg <= volts_reg;
            out_chg_reg  <= charge_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.avg_voltage = out_volt_reg;
    assign res.charge_pct  = out_chg_reg;
endmodule

`default_nettype wire

### rtl/bse_checker.sv
// Port-level assertions for the estimator, bound to its top level.
// Depends on bse_pkg and on battery_soc_estimator's interface ports.
`default_nettype none

module bse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_type,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [bse_pkg::VOLT_W-1:0] res_avg_voltage,
    input logic [bse_pkg::CHG_W-1:0]  res_charge_pct
);
    import bse_pkg::*;

    // the sequencer leaves idle right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the sequencer was still busy");

    // table writes produce no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type |=> !$rose(res_valid))
        else $error("result raised by a table write request");

    // an average can never exceed full-scale volts
    a_volt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_avg_voltage <= VOLT_W'(VOLT_NUM)))
        else $error("average voltage above full scale");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_avg_voltage)
            && $stable(res_charge_pct))
        else $error("stalled result changed");
endmodule

bind battery_soc_estimator bse_checker u_bse_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_type        (req.req_type),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_avg_voltage (res.avg_voltage),
    .res_charge_pct  (res.charge_pct)
);

`default_nettype wire
